// ----- design/nggp_pkg.sv -----
`timescale 1ns / 1ps

package nggp_pkg;

    // ascii codes seen by the parser
    localparam logic [7:0] ASCII_NL     = 8'h0A;
    localparam logic [7:0] ASCII_DOLLAR = 8'h24;
    localparam logic [7:0] ASCII_COMMA  = 8'h2C;
    localparam logic [7:0] ASCII_DOT    = 8'h2E;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_NINE   = 8'h39;
    localparam logic [7:0] ASCII_A      = 8'h41;
    localparam logic [7:0] ASCII_G      = 8'h47;
    localparam logic [7:0] ASCII_S      = 8'h53;
    localparam logic [7:0] ASCII_W      = 8'h57;

    // talker id after reset: "GN"
    localparam logic [15:0] TALKER_RESET = 16'h474E;

    // sentence header is '$', two talker characters, then GGA
    localparam int HDR_LEN = 6;

    // field numbers within a sentence
    localparam logic [3:0] FIELD_TIME = 4'd1;
    localparam logic [3:0] FIELD_LAT  = 4'd2;
    localparam logic [3:0] FIELD_NS   = 4'd3;
    localparam logic [3:0] FIELD_LON  = 4'd4;
    localparam logic [3:0] FIELD_EW   = 4'd5;
    localparam logic [3:0] FIELD_MAX  = 4'd15;
    localparam logic [3:0] POS_MAX    = 4'd15;

    // integer part of a coordinate saturates here
    localparam logic [16:0] INT_SAT = 17'd99999;

    // x / 100 == (x * 167773) >> 24, exact for x up to 99999
    localparam logic [17:0] DIV100_MUL = 18'd167773;
    // x / 15 == (x * 286331154) >> 32, exact for x below 2^28
    localparam logic [28:0] DIV15_MUL  = 29'd286331154;
    localparam logic [23:0] E7         = 24'd10000000;

    // expected character at a header position
    function automatic logic [7:0] hdr_char(input logic [2:0] pos, input logic [15:0] talker);
        logic [7:0] ch;
        case (pos)
            3'd0: ch = ASCII_DOLLAR;
            3'd1: ch = talker[15:8];
            3'd2: ch = talker[7:0];
            3'd3: ch = ASCII_G;
            3'd4: ch = ASCII_G;
            default: ch = ASCII_A;
        endcase
        return ch;
    endfunction

endpackage

// ----- design/nmea_gga_position_parser.sv -----
`timescale 1ns / 1ps
// NMEA GGA position parser.
// Input channel s_*: one received character per transaction in s_rx_byte.
// Result channel m_*: one transaction per newline that ends a sentence
// starting with '$', the talker id and GGA; it carries UTC hour, minute,
// second and latitude / longitude in signed degrees times 10^7.
// cfg_wr_en / cfg_wr_data write the two-character talker id (first char high).
// Throughput: one character per cycle while s_ready is high; every character goes
// through the parser registers in the cycle it is accepted.
// A result passes from its newline through conversion stages 0 to 3 and the
// output register to m_valid (divide by 100, scale, reciprocal of 15, sign).
// Stall: while m_ready is low the pipeline keeps filling; s_ready drops only
// when the four conversion stages and the output register all hold a result.
// Reset (aresetn low, synchronous): talker id back to "GN", line state
// cleared, pipeline emptied, no result pending.
module nmea_gga_position_parser #(
    parameter int LINE_LIMIT  = 99,
    parameter int FRAC_DIGITS = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [6:0]          m_hour,
    output logic [6:0]          m_minute,
    output logic [6:0]          m_second,
    output logic signed [34:0]  m_latitude_e7,
    output logic signed [34:0]  m_longitude_e7
);

    localparam int FW = $clog2(10 ** FRAC_DIGITS);

    logic              line_valid;
    logic [5:0][3:0]   time_digits;
    logic [16:0]       lat_int, lon_int;
    logic [FW-1:0]     lat_frac, lon_frac;
    logic              south, west;

    // character parser and line state
    nggp_parser #(
        .LINE_LIMIT  (LINE_LIMIT),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (s_valid),
        .byte_ready  (s_ready),
        .rx_byte     (s_rx_byte),
        .line_valid  (line_valid),
        .time_digits (time_digits),
        .lat_int     (lat_int),
        .lat_frac    (lat_frac),
        .lon_int     (lon_int),
        .lon_frac    (lon_frac),
        .south       (south),
        .west        (west)
    );

    // conversion pipeline and result register
    nggp_convert #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_convert (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (line_valid),
        .in_ready     (s_ready),
        .time_digits  (time_digits),
        .lat_int      (lat_int),
        .lat_frac     (lat_frac),
        .lon_int      (lon_int),
        .lon_frac     (lon_frac),
        .south        (south),
        .west         (west),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .hour         (m_hour),
        .minute       (m_minute),
        .second       (m_second),
        .latitude_e7  (m_latitude_e7),
        .longitude_e7 (m_longitude_e7)
    );

endmodule

// ----- design/nggp_parser.sv -----
`timescale 1ns / 1ps

module nggp_parser #(
    parameter int LINE_LIMIT  = 99,
    parameter int FRAC_DIGITS = 5,
    localparam int CW = $clog2(LINE_LIMIT + 1),
    localparam int FW = $clog2(10 ** FRAC_DIGITS),
    localparam int DW = $clog2(FRAC_DIGITS + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                byte_valid,
    input  logic                byte_ready,
    input  logic [7:0]          rx_byte,
    output logic                line_valid,
    output logic [5:0][3:0]     time_digits,
    output logic [16:0]         lat_int,
    output logic [FW-1:0]       lat_frac,
    output logic [16:0]         lon_int,
    output logic [FW-1:0]       lon_frac,
    output logic                south,
    output logic                west
);

    logic [15:0]      talker_id_reg;
    logic [CW-1:0]    char_count_reg, char_count_next;
    logic             header_ok_reg, header_ok_next;
    logic [3:0]       field_number_reg, field_number_next;
    logic [3:0]       field_char_pos_reg, field_char_pos_next;
    logic [5:0][3:0]  time_digits_reg, time_digits_next;
    logic [16:0]      lat_int_reg, lat_int_next;
    logic [FW-1:0]    lat_frac_reg, lat_frac_next;
    logic [16:0]      lon_int_reg, lon_int_next;
    logic [FW-1:0]    lon_frac_reg, lon_frac_next;
    logic [DW-1:0]    frac_cnt_reg, frac_cnt_next;
    logic             after_point_reg, after_point_next;
    logic             south_reg, south_next;
    logic             west_reg, west_next;

    logic             accept;
    logic             is_nl;
    logic             is_digit;
    logic [3:0]       digit;
    logic [16:0]      num_int;
    logic [FW-1:0]    num_frac;
    logic [19:0]      int_calc;
    logic [16:0]      int_new;
    logic [FW-1:0]    frac_new;
    logic [DW-1:0]    frac_cnt_new;
    logic             after_point_new;
    logic             line_match;

    assign accept   = byte_valid && byte_ready;
    assign is_nl    = (rx_byte == nggp_pkg::ASCII_NL);
    assign is_digit = (rx_byte >= nggp_pkg::ASCII_ZERO) && (rx_byte <= nggp_pkg::ASCII_NINE);
    assign digit    = is_digit ? 4'(rx_byte - nggp_pkg::ASCII_ZERO) : 4'd0;

    // a finished line goes to the converter on its newline
    assign line_match = header_ok_reg && (char_count_reg >= CW'(nggp_pkg::HDR_LEN));
    assign line_valid = byte_valid && is_nl && line_match;

    // shared number accumulator for latitude and longitude
    assign num_int  = (field_number_reg == nggp_pkg::FIELD_LAT) ? lat_int_reg : lon_int_reg;
    assign num_frac = (field_number_reg == nggp_pkg::FIELD_LAT) ? lat_frac_reg : lon_frac_reg;
    assign int_calc = {3'b000, num_int} * 20'd10 + 20'(digit);
    assign int_new  = (int_calc > 20'(nggp_pkg::INT_SAT)) ? nggp_pkg::INT_SAT : int_calc[16:0];

    always_comb begin
        frac_new        = num_frac;
        frac_cnt_new    = frac_cnt_reg;
        after_point_new = after_point_reg;
        if (is_digit) begin
            if (after_point_reg && (frac_cnt_reg < DW'(FRAC_DIGITS))) begin
                frac_new     = FW'(num_frac * FW'(10) + FW'(digit));
                frac_cnt_new = frac_cnt_reg + DW'(1);
            end
        end else if (rx_byte == nggp_pkg::ASCII_DOT && !after_point_reg) begin
            after_point_new = 1'b1;
        end else begin
            // anything else ends the number
            after_point_new = 1'b1;
            frac_cnt_new    = DW'(FRAC_DIGITS);
        end
    end

    // line state update
    always_comb begin
        char_count_next     = char_count_reg;
        header_ok_next      = header_ok_reg;
        field_number_next   = field_number_reg;
        field_char_pos_next = field_char_pos_reg;
        time_digits_next    = time_digits_reg;
        lat_int_next        = lat_int_reg;
        lat_frac_next       = lat_frac_reg;
        lon_int_next        = lon_int_reg;
        lon_frac_next       = lon_frac_reg;
        frac_cnt_next       = frac_cnt_reg;
        after_point_next    = after_point_reg;
        south_next          = south_reg;
        west_next           = west_reg;
        if (accept) begin
            if (is_nl) begin
                char_count_next     = '0;
                header_ok_next      = 1'b1;
                field_number_next   = '0;
                field_char_pos_next = '0;
                time_digits_next    = '0;
                lat_int_next        = '0;
                lat_frac_next       = '0;
                lon_int_next        = '0;
                lon_frac_next       = '0;
                frac_cnt_next       = '0;
                after_point_next    = 1'b0;
                south_next          = 1'b0;
                west_next           = 1'b0;
            end else if (char_count_reg < CW'(LINE_LIMIT)) begin
                if (char_count_reg < CW'(nggp_pkg::HDR_LEN)
                    && rx_byte != nggp_pkg::hdr_char(char_count_reg[2:0], talker_id_reg)) begin
                    header_ok_next = 1'b0;
                end
                char_count_next = char_count_reg + CW'(1);
                if (rx_byte == nggp_pkg::ASCII_COMMA) begin
                    if (field_number_reg < nggp_pkg::FIELD_MAX) begin
                        field_number_next = field_number_reg + 4'd1;
                    end
                    field_char_pos_next = '0;
                    after_point_next    = 1'b0;
                    frac_cnt_next       = '0;
                end else begin
                    case (field_number_reg)
                        nggp_pkg::FIELD_TIME: begin
                            for (int i = 0; i < 6; i++) begin
                                if (field_char_pos_reg == 4'(i)) begin
                                    time_digits_next[i] = digit;
                                end
                            end
                        end
                        nggp_pkg::FIELD_LAT: begin
                            if (is_digit && !after_point_reg) begin
                                lat_int_next = int_new;
                            end
                            lat_frac_next    = frac_new;
                            frac_cnt_next    = frac_cnt_new;
                            after_point_next = after_point_new;
                        end
                        nggp_pkg::FIELD_NS: begin
                            if (field_char_pos_reg == 4'd0) begin
                                south_next = (rx_byte == nggp_pkg::ASCII_S);
                            end
                        end
                        nggp_pkg::FIELD_LON: begin
                            if (is_digit && !after_point_reg) begin
                                lon_int_next = int_new;
                            end
                            lon_frac_next    = frac_new;
                            frac_cnt_next    = frac_cnt_new;
                            after_point_next = after_point_new;
                        end
                        nggp_pkg::FIELD_EW: begin
                            if (field_char_pos_reg == 4'd0) begin
                                west_next = (rx_byte == nggp_pkg::ASCII_W);
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (field_char_pos_reg < nggp_pkg::POS_MAX) begin
                        field_char_pos_next = field_char_pos_reg + 4'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            talker_id_reg      <= nggp_pkg::TALKER_RESET;
            char_count_reg     <= '0;
            header_ok_reg      <= 1'b1;
            field_number_reg   <= '0;
            field_char_pos_reg <= '0;
            time_digits_reg    <= '0;
            lat_int_reg        <= '0;
            lat_frac_reg       <= '0;
            lon_int_reg        <= '0;
            lon_frac_reg       <= '0;
            frac_cnt_reg       <= '0;
            after_point_reg    <= 1'b0;
            south_reg          <= 1'b0;
            west_reg           <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                talker_id_reg <= cfg_wr_data;
            end
            char_count_reg     <= char_count_next;
            header_ok_reg      <= header_ok_next;
            field_number_reg   <= field_number_next;
            field_char_pos_reg <= field_char_pos_next;
            time_digits_reg    <= time_digits_next;
            lat_int_reg        <= lat_int_next;
            lat_frac_reg       <= lat_frac_next;
            lon_int_reg        <= lon_int_next;
            lon_frac_reg       <= lon_frac_next;
            frac_cnt_reg       <= frac_cnt_next;
            after_point_reg    <= after_point_next;
            south_reg          <= south_next;
            west_reg           <= west_next;
        end
    end

    assign time_digits = time_digits_reg;
    assign lat_int     = lat_int_reg;
    assign lat_frac    = lat_frac_reg;
    assign lon_int     = lon_int_reg;
    assign lon_frac    = lon_frac_reg;
    assign south       = south_reg;
    assign west        = west_reg;

endmodule

// ----- design/nggp_convert.sv -----
`timescale 1ns / 1ps

module nggp_convert #(
    parameter int FRAC_DIGITS = 5,
    localparam int FW = $clog2(10 ** FRAC_DIGITS),
    localparam int SCALE = 10 ** (7 - FRAC_DIGITS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [5:0][3:0]     time_digits,
    input  logic [16:0]         lat_int,
    input  logic [FW-1:0]       lat_frac,
    input  logic [16:0]         lon_int,
    input  logic [FW-1:0]       lon_frac,
    input  logic                south,
    input  logic                west,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [6:0]          hour,
    output logic [6:0]          minute,
    output logic [6:0]          second,
    output logic signed [34:0]  latitude_e7,
    output logic signed [34:0]  longitude_e7
);

    // lane 0 is latitude, lane 1 is longitude
    logic [16:0]    ip_in [2];
    logic [FW-1:0]  fp_in [2];
    logic           neg_in [2];

    logic [3:0]     v_reg;
    logic [4:0]     rdy;

    logic [6:0]     hour_reg [4];
    logic [6:0]     minute_reg [4];
    logic [6:0]     second_reg [4];
    logic           neg_reg [4][2];

    logic [16:0]    ip_s0_reg [2];
    logic [9:0]     q_s0_reg [2];
    logic [FW-1:0]  fp_s0_reg [2];
    logic [6:0]     mm_s1_reg [2];
    logic [FW-1:0]  fp_s1_reg [2];
    logic [33:0]    deg_reg [3][2];
    logic [29:0]    y_s2_reg [2];
    logic [24:0]    x_s3_reg [2];

    logic           out_valid_reg;
    logic [6:0]     hour_out_reg, minute_out_reg, second_out_reg;
    logic [34:0]    lat_out_reg, lon_out_reg;

    logic [33:0]    q_prod [2];
    logic [16:0]    mm_full [2];
    logic [56:0]    x_prod [2];
    logic [34:0]    sum [2];

    assign ip_in[0]  = lat_int;
    assign ip_in[1]  = lon_int;
    assign fp_in[0]  = lat_frac;
    assign fp_in[1]  = lon_frac;
    assign neg_in[0] = south;
    assign neg_in[1] = west;

    // elastic pipeline: a stage takes new data when empty or moving on
    always_comb begin
        rdy[4] = !out_valid_reg || out_ready;
        for (int k = 3; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end
    assign in_ready = rdy[0];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            q_prod[i]  = {17'd0, ip_in[i]} * {16'd0, nggp_pkg::DIV100_MUL};
            mm_full[i] = ip_s0_reg[i] - {7'd0, q_s0_reg[i]} * 17'd100;
            x_prod[i]  = 57'(y_s2_reg[i][29:2]) * 57'(nggp_pkg::DIV15_MUL);
            sum[i]     = {1'b0, deg_reg[2][i]} + 35'(x_s3_reg[i]);
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < 4; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (rdy[4]) begin
                out_valid_reg <= v_reg[3];
            end
        end
    end

    // stage 0: time fields and degrees by division by 100
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            hour_reg[0]   <= {3'd0, time_digits[0]} * 7'd10 + {3'd0, time_digits[1]};
            minute_reg[0] <= {3'd0, time_digits[2]} * 7'd10 + {3'd0, time_digits[3]};
            second_reg[0] <= {3'd0, time_digits[4]} * 7'd10 + {3'd0, time_digits[5]};
            for (int i = 0; i < 2; i++) begin
                ip_s0_reg[i]  <= ip_in[i];
                q_s0_reg[i]   <= q_prod[i][33:24];
                fp_s0_reg[i]  <= fp_in[i];
                neg_reg[0][i] <= neg_in[i];
            end
        end
    end

    // stage 1: whole minutes and scaled degrees
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            hour_reg[1]   <= hour_reg[0];
            minute_reg[1] <= minute_reg[0];
            second_reg[1] <= second_reg[0];
            for (int i = 0; i < 2; i++) begin
                mm_s1_reg[i]  <= mm_full[i][6:0];
                deg_reg[0][i] <= {24'd0, q_s0_reg[i]} * {10'd0, nggp_pkg::E7};
                fp_s1_reg[i]  <= fp_s0_reg[i];
                neg_reg[1][i] <= neg_reg[0][i];
            end
        end
    end

    // stage 2: minutes times 10^7 over the fraction scale
    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            hour_reg[2]   <= hour_reg[1];
            minute_reg[2] <= minute_reg[1];
            second_reg[2] <= second_reg[1];
            for (int i = 0; i < 2; i++) begin
                y_s2_reg[i]   <= {23'd0, mm_s1_reg[i]} * {6'd0, nggp_pkg::E7}
                                 + 30'(fp_s1_reg[i]) * 30'(SCALE);
                deg_reg[1][i] <= deg_reg[0][i];
                neg_reg[2][i] <= neg_reg[1][i];
            end
        end
    end

    // stage 3: divide by 60 as a shift by 2 and a reciprocal of 15
    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            hour_reg[3]   <= hour_reg[2];
            minute_reg[3] <= minute_reg[2];
            second_reg[3] <= second_reg[2];
            for (int i = 0; i < 2; i++) begin
                x_s3_reg[i]   <= x_prod[i][56:32];
                deg_reg[2][i] <= deg_reg[1][i];
                neg_reg[3][i] <= neg_reg[2][i];
            end
        end
    end

    // output register: add and apply hemisphere sign
    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            hour_out_reg   <= hour_reg[3];
            minute_out_reg <= minute_reg[3];
            second_out_reg <= second_reg[3];
            lat_out_reg    <= neg_reg[3][0] ? (35'd0 - sum[0]) : sum[0];
            lon_out_reg    <= neg_reg[3][1] ? (35'd0 - sum[1]) : sum[1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign hour         = hour_out_reg;
    assign minute       = minute_out_reg;
    assign second       = second_out_reg;
    assign latitude_e7  = signed'(lat_out_reg);
    assign longitude_e7 = signed'(lon_out_reg);

endmodule

// ----- design/nggp_port_checker.sv -----
`timescale 1ns / 1ps

module nggp_port_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [6:0]          m_hour,
    input logic [6:0]          m_minute,
    input logic [6:0]          m_second,
    input logic signed [34:0]  m_latitude_e7,
    input logic signed [34:0]  m_longitude_e7
);

    // a stalled result transaction holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hour) && $stable(m_minute)
            && $stable(m_second) && $stable(m_latitude_e7) && $stable(m_longitude_e7))
    else $error("result changed while stalled");

    // input backpressure only when the output side is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
    else $error("input stalled without output stall");

    // time fields are built from two decimal digits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hour <= 7'd99) && (m_minute <= 7'd99) && (m_second <= 7'd99))
    else $error("time field out of range");

    // coordinate magnitudes stay within 999 degrees plus 100 minutes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_latitude_e7 <= 35'sd10006666666) && (m_latitude_e7 >= -35'sd10006666666)
            && (m_longitude_e7 <= 35'sd10006666666) && (m_longitude_e7 >= -35'sd10006666666))
    else $error("coordinate out of range");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
    else $error("result pending after reset");

endmodule

bind nmea_gga_position_parser nggp_port_checker u_port_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_hour         (m_hour),
    .m_minute       (m_minute),
    .m_second       (m_second),
    .m_latitude_e7  (m_latitude_e7),
    .m_longitude_e7 (m_longitude_e7)
);

// ----- test/nmea_gga_position_parser_tb.sv -----
`timescale 1ns / 1ps

module nmea_gga_position_parser_tb;

    localparam int LINE_MAX     = 99;
    localparam int FRAC_MAX     = 5;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int SHOW_MAX     = 10;
    localparam int SEG_BYTES    = 40;

    typedef struct packed {
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [34:0] lat_e7;
        logic [34:0] lon_e7;
    } gga_fix_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [15:0]        cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte   = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [6:0]         m_hour;
    logic [6:0]         m_minute;
    logic [6:0]         m_second;
    logic signed [34:0] m_latitude_e7;
    logic signed [34:0] m_longitude_e7;

    // sentence tracking state of the predictor
    logic [15:0] talker_model = nggp_pkg::TALKER_RESET;
    int          line_len;
    bit          hdr_match;
    logic [3:0]  fld_num;
    logic [3:0]  fld_pos;
    logic [3:0]  tdig [6];
    int unsigned lat_i, lat_f, lon_i, lon_f;
    int          frac_cnt;
    bit          in_frac;
    bit          south, west;

    // expected fixes and bookkeeping
    gga_fix_t    fix_q [$];
    logic [7:0]  line_buf [$];
    int          fix_count      = 0;
    int          byte_count     = 0;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    bit          tx_quiet       = 1'b0;
    bit          rx_quiet       = 1'b0;
    bit          hold_req       = 1'b0;
    int          rx_stall       = 0;
    int          hold_cnt       = 0;

    nmea_gga_position_parser #(
        .LINE_LIMIT  (LINE_MAX),
        .FRAC_DIGITS (FRAC_MAX)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hour         (m_hour),
        .m_minute       (m_minute),
        .m_second       (m_second),
        .m_latitude_e7  (m_latitude_e7),
        .m_longitude_e7 (m_longitude_e7)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic bit is_digit(logic [7:0] c);
        return c >= nggp_pkg::ASCII_ZERO && c <= nggp_pkg::ASCII_NINE;
    endfunction

    function automatic logic [7:0] expected_hdr_byte(int pos);
        case (pos)
            0:       return nggp_pkg::ASCII_DOLLAR;
            1:       return talker_model[15:8];
            2:       return talker_model[7:0];
            3, 4:    return nggp_pkg::ASCII_G;
            default: return nggp_pkg::ASCII_A;
        endcase
    endfunction

    // ddmm.fffff to signed degrees * 1e7, truncated
    function automatic logic [34:0] coord_e7(int unsigned ip, int unsigned fp, bit neg);
        longint unsigned scale;
        longint unsigned deg;
        longint unsigned mins;
        longint unsigned v;
        scale = 1;
        for (int i = 0; i < FRAC_MAX; i++) scale = scale * 10;
        deg  = ip / 100;
        mins = longint'(ip % 100) * scale + fp;
        v    = deg * 64'd10000000 + (mins * 64'd10000000) / (64'd60 * scale);
        if (neg) v = 64'd0 - v;
        return v[34:0];
    endfunction

    task automatic clear_line_state();
        line_len  = 0;
        hdr_match = 1'b1;
        fld_num   = '0;
        fld_pos   = '0;
        foreach (tdig[i]) tdig[i] = '0;
        lat_i     = 0;
        lat_f     = 0;
        lon_i     = 0;
        lon_f     = 0;
        frac_cnt  = 0;
        in_frac   = 1'b0;
        south     = 1'b0;
        west      = 1'b0;
    endtask

    // one character of a coordinate field
    task automatic coord_char(logic [7:0] c, inout int unsigned ip, inout int unsigned fp);
        if (is_digit(c)) begin
            if (!in_frac) begin
                ip = ip * 10 + (c - nggp_pkg::ASCII_ZERO);
                if (ip > nggp_pkg::INT_SAT) ip = nggp_pkg::INT_SAT;
            end else if (frac_cnt < FRAC_MAX) begin
                fp = fp * 10 + (c - nggp_pkg::ASCII_ZERO);
                frac_cnt++;
            end
        end else if (c == nggp_pkg::ASCII_DOT && !in_frac) begin
            in_frac = 1'b1;
        end else begin
            // anything else ends the number
            in_frac  = 1'b1;
            frac_cnt = FRAC_MAX;
        end
    endtask

    task automatic predict_char(logic [7:0] c);
        gga_fix_t f;
        // end of line: emit a fix if the header matched
        if (c == nggp_pkg::ASCII_NL) begin
            if (hdr_match && line_len >= nggp_pkg::HDR_LEN) begin
                f.hour   = 7'(tdig[0] * 10 + tdig[1]);
                f.minute = 7'(tdig[2] * 10 + tdig[3]);
                f.second = 7'(tdig[4] * 10 + tdig[5]);
                f.lat_e7 = coord_e7(lat_i, lat_f, south);
                f.lon_e7 = coord_e7(lon_i, lon_f, west);
                fix_q.push_back(f);
                fix_count++;
            end
            clear_line_state();
            return;
        end
        if (line_len >= LINE_MAX) return;
        if (line_len < nggp_pkg::HDR_LEN && c != expected_hdr_byte(line_len)) hdr_match = 1'b0;
        line_len++;
        // field separator
        if (c == nggp_pkg::ASCII_COMMA) begin
            if (fld_num < nggp_pkg::FIELD_MAX) fld_num++;
            fld_pos  = '0;
            in_frac  = 1'b0;
            frac_cnt = 0;
            return;
        end
        case (fld_num)
            nggp_pkg::FIELD_TIME: begin
                if (fld_pos < 6)
                    tdig[fld_pos] = is_digit(c) ? 4'(c - nggp_pkg::ASCII_ZERO) : 4'd0;
            end
            nggp_pkg::FIELD_LAT:  coord_char(c, lat_i, lat_f);
            nggp_pkg::FIELD_NS:   if (fld_pos == 0) south = (c == nggp_pkg::ASCII_S);
            nggp_pkg::FIELD_LON:  coord_char(c, lon_i, lon_f);
            nggp_pkg::FIELD_EW:   if (fld_pos == 0) west = (c == nggp_pkg::ASCII_W);
            default: ;
        endcase
        if (fld_pos < nggp_pkg::POS_MAX) fld_pos++;
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic compare_field(string name, logic [34:0] want, logic [34:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_MAX)
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, name, $signed(want), $signed(got));
        end
    endtask

    task automatic check_fix();
        gga_fix_t want;
        if (fix_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_MAX)
                $display("%0t: result transaction with no fix expected", $time);
            return;
        end
        want = fix_q.pop_front();
        compare_field("hour", 35'(want.hour), 35'(m_hour));
        compare_field("minute", 35'(want.minute), 35'(m_minute));
        compare_field("second", 35'(want.second), 35'(m_second));
        compare_field("latitude_e7", want.lat_e7, m_latitude_e7);
        compare_field("longitude_e7", want.lon_e7, m_longitude_e7);
    endtask

    // monitor: config, accepted characters, results, watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            talker_model = nggp_pkg::TALKER_RESET;
            clear_line_state();
        end else begin
            if (cfg_wr_en) talker_model = cfg_wr_data;
            if (s_valid && s_ready) begin
                predict_char(s_rx_byte);
                byte_count++;
            end
            if (m_valid && m_ready) check_fix();
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // idling and result-side stalls
    // ------------------------------------------------------------------

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result ready, with a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            m_ready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES) begin
                hold_cnt = 0;
                hold_req = 1'b0;
            end
        end else if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else begin
            if ($urandom_range(0, 199) == 0) rx_quiet = !rx_quiet;
            rx_stall = pick_gap(rx_quiet);
            m_ready <= (rx_stall == 0);
            if (rx_stall > 0) rx_stall--;
        end
    end

    // ------------------------------------------------------------------
    // character driver
    // ------------------------------------------------------------------

    task automatic send_byte(logic [7:0] c);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_rx_byte <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_line_buf();
        foreach (line_buf[i]) send_byte(line_buf[i]);
        line_buf.delete();
    endtask

    // drop valid, let every expected fix drain, then let the pipeline settle
    task automatic wait_idle();
        @(negedge aclk) s_valid <= 1'b0;
        while (fix_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_talker(logic [15:0] id);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= id;
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // random sentence builder
    // ------------------------------------------------------------------

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void push_digits(int n);
        repeat (n) line_buf.push_back(nggp_pkg::ASCII_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void push_time();
        case ($urandom_range(0, 15))
            0: ;
            1: push_digits($urandom_range(1, 5));
            2: begin
                push_digits(2);
                line_buf.push_back(8'($urandom_range(32, 126)));
                push_digits(3);
            end
            3: push_digits($urandom_range(7, 18));
            default: begin
                push_digits(6);
                if ($urandom_range(0, 1) == 1) begin
                    line_buf.push_back(nggp_pkg::ASCII_DOT);
                    push_digits(2);
                end
            end
        endcase
    endfunction

    function automatic void push_coord(int int_digits);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return;
        if (r == 1) begin
            push_str("99999.99999");
            return;
        end
        if (r == 5) push_str("-");
        push_digits(r == 2 ? $urandom_range(0, 7) : int_digits);
        if ($urandom_range(0, 9) != 0) begin
            line_buf.push_back(nggp_pkg::ASCII_DOT);
            push_digits($urandom_range(0, 7));
        end
        if (r == 3) push_str(".5.5");
        if (r == 4) push_str(" 12");
    endfunction

    function automatic void push_flag(string pair);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return;
        line_buf.push_back(pair[$urandom_range(0, 1)]);
        if (r == 1) line_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
    endfunction

    function automatic void gen_random_line();
        int kind;
        int cut;
        kind = $urandom_range(0, 99);
        // pure noise, any byte value
        if (kind < 10) begin
            repeat ($urandom_range(1, 40)) line_buf.push_back(8'($urandom_range(0, 255)));
            line_buf.push_back(nggp_pkg::ASCII_NL);
            return;
        end
        line_buf.push_back(nggp_pkg::ASCII_DOLLAR);
        if (kind < 15) begin
            line_buf.push_back(8'($urandom_range(0, 255)));
            line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            line_buf.push_back(talker_model[15:8]);
            line_buf.push_back(talker_model[7:0]);
        end
        if (kind >= 15 && kind < 20) push_str("RMC");
        else push_str("GGA");
        if ($urandom_range(0, 7) == 0) line_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
        line_buf.push_back(nggp_pkg::ASCII_COMMA);
        push_time();
        line_buf.push_back(nggp_pkg::ASCII_COMMA);
        push_coord(4);
        line_buf.push_back(nggp_pkg::ASCII_COMMA);
        push_flag("NS");
        line_buf.push_back(nggp_pkg::ASCII_COMMA);
        push_coord(5);
        line_buf.push_back(nggp_pkg::ASCII_COMMA);
        push_flag("EW");
        // trailing fields
        repeat ($urandom_range(0, 9)) begin
            line_buf.push_back(nggp_pkg::ASCII_COMMA);
            push_digits($urandom_range(0, 3));
        end
        if ($urandom_range(0, 3) == 0) push_str("*47");
        // padding that runs past the line limit
        if ($urandom_range(0, 14) == 0)
            repeat ($urandom_range(30, 80)) line_buf.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 1) == 1) push_str("\r");
        // broken sentence: cut short or one byte corrupted
        if (kind >= 88) begin
            cut = $urandom_range(0, line_buf.size() - 1);
            if (kind < 94) begin
                while (line_buf.size() > cut) void'(line_buf.pop_back());
            end else begin
                line_buf[cut] = 8'($urandom_range(0, 255));
            end
        end
        line_buf.push_back(nggp_pkg::ASCII_NL);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_standard_sentences();
        send_str("$GNGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");
        send_str("$GNGGA,235959.00,3351.12345,S,15112.54321,W,1,12,0.6,20.1,M,,M,,*5A\n");
        send_str("$GNGGA,000000,0000.00000,N,00000.00000,E\n");
        send_str("$GNGGA,999999,99999.99999,S,99999.99999,W\n");
        wait_idle();
    endtask

    task automatic test_header_matching();
        // empty and short lines never match; a bare header line does
        send_str("\n");
        send_str("$GNG\n");
        send_str("$GNGGA\n");
        send_str("$GPGGA,101010,1234.5,N,01234.5,E\n");
        send_str("$GNRMC,101010,1234.5,N,01234.5,E\n");
        send_str("GNGGA,101010,1234.5,N,01234.5,E\n");
        // letters after GGA are not checked
        send_str("$GNGGAXYZ,111213,4530.5,N,07330.25,W\n");
        wait_idle();
    endtask

    task automatic test_field_syntax();
        send_str("$GNGGA,1a2 3x,4807.038,N,01131.000,E\n");
        send_str("$GNGGA,,,,,\n");
        send_str("$GNGGA,12\n");
        // saturated integer part, extra fraction digits, leading sign
        send_str("$GNGGA,123456,1234567.1234567,N,-0123.5,E\n");
        // second point, embedded space, flag only from first character
        send_str("$GNGGA,123456,4807.03.8,SN,0113 1.5,WEST\n");
        send_str("$GNGGA,123456,4807.038,n,01131.000,w\n");
        send_str("$GNGGA,123456,4807.038,xS,01131.000,xW\n");
        // position and field count saturation
        send_str("$GNGGA,1234567890123456789,.5,S,.,W\n");
        send_str("$GNGGA,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17,18,19,20\n");
        // carriage return and zero byte as plain characters
        send_str("$GNGGA,12\r4");
        send_byte(8'h00);
        send_str("6,48\r07.5,S\r,0113");
        send_byte(8'h00);
        send_str("1.5,W\n");
        wait_idle();
    endtask

    task automatic test_line_limit();
        // longitude is cut by the line limit
        push_str("$GNGGA,010203,4807.038,S");
        repeat (70) line_buf.push_back("x");
        push_str(",01131.000,W\n");
        send_line_buf();
        // separators past the limit are ignored
        push_str("$GNGGA,235900,1234.5,N,");
        repeat (120) line_buf.push_back(nggp_pkg::ASCII_COMMA);
        push_str("00001.5,W\n");
        send_line_buf();
        wait_idle();
    endtask

    task automatic test_result_backpressure();
        tx_quiet = 1'b1;
        hold_req = 1'b1;
        repeat (12) send_str("$GNGGA,1\n");
        wait (!hold_req);
        tx_quiet = 1'b0;
        wait_idle();
    endtask

    task automatic test_talker_config();
        write_talker(16'h4750);
        send_str("$GPGGA,081530,5130.12345,N,00007.65432,W\n");
        send_str("$GNGGA,081530,5130.12345,N,00007.65432,W\n");
        // talker change in the middle of a header
        send_str("$G");
        write_talker(16'h474C);
        send_str("LGGA,120000,3000.0,S,04500.0,E\n");
        write_talker(16'h0000);
        send_byte(nggp_pkg::ASCII_DOLLAR);
        send_byte(8'h00);
        send_byte(8'h00);
        send_str("GGA,010101,0100.5,N,00100.5,E\n");
        write_talker(16'hFFFF);
        send_byte(nggp_pkg::ASCII_DOLLAR);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_str("GGA,020202,8959.99999,S,17959.99999,W\n");
        send_str("$GNGGA,020202,1000.0,N,01000.0,E\n");
        // newline as a talker character can never match
        write_talker(16'h0A0A);
        send_str("$\nGGA,010101\n");
        write_talker(nggp_pkg::TALKER_RESET);
        send_str("$GNGGA,030303,0130.0,N,00130.0,E\n");
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [15:0] seg_talker [4];
        int          seg_bytes;
        int          seg_fixes;
        seg_talker[0] = nggp_pkg::TALKER_RESET;
        seg_talker[1] = {8'($urandom_range(8'h41, 8'h5A)), 8'($urandom_range(8'h41, 8'h5A))};
        seg_talker[2] = 16'h4750;
        do seg_talker[3] = 16'($urandom);
        while (seg_talker[3][15:8] == nggp_pkg::ASCII_NL
               || seg_talker[3][7:0] == nggp_pkg::ASCII_NL);
        foreach (seg_talker[s]) begin
            write_talker(seg_talker[s]);
            seg_bytes = byte_count;
            seg_fixes = fix_count;
            while (byte_count - seg_bytes < SEG_BYTES || fix_count - seg_fixes < 1) begin
                if ($urandom_range(0, 9) == 0) tx_quiet = !tx_quiet;
                gen_random_line();
                send_line_buf();
            end
        end
        tx_quiet = 1'b0;
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        test_standard_sentences();
        test_header_matching();
        test_field_syntax();
        test_line_limit();
        test_result_backpressure();
        test_talker_config();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0 && fix_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
